[rtl/fen_position_parser_unit_defines.svh]
// Assertion macros for the checker module.
`ifndef FEN_POSITION_PARSER_UNIT_DEFINES_SVH
`define FEN_POSITION_PARSER_UNIT_DEFINES_SVH

// Clocked check, quiet while reset is asserted.
`define FPP_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also runs during reset.
`define FPP_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/fpp_pkg.sv]
`timescale 1ns / 1ps
package fpp_pkg;

	// parser phases
	typedef enum logic [2:0] {
		PH_PLACE,
		PH_TURN,
		PH_SPACE,
		PH_CASTLE,
		PH_EP_FILE,
		PH_EP_RANK,
		PH_DONE,
		PH_ERROR
	} phase_t;

	// status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_BAD_PLACE   = 4'd1;
	localparam logic [3:0] ST_ENDED_EARLY = 4'd2;
	localparam logic [3:0] ST_BAD_TURN    = 4'd3;
	localparam logic [3:0] ST_NO_SPACE    = 4'd4;
	localparam logic [3:0] ST_DUP_CASTLE  = 4'd5;
	localparam logic [3:0] ST_BAD_CASTLE  = 4'd6;
	localparam logic [3:0] ST_BAD_EP_FILE = 4'd7;
	localparam logic [3:0] ST_BAD_EP_RANK = 4'd8;
	localparam logic [3:0] ST_OFF_BOARD   = 4'd9;

	// piece codes
	localparam logic [3:0] PC_NONE   = 4'd0;
	localparam logic [3:0] PC_W_KING = 4'd6;
	localparam logic [3:0] PC_B_KING = 4'd12;

	// characters
	localparam logic [7:0] CH_A     = 8'h61; // 'a'
	localparam logic [7:0] CH_H     = 8'h68; // 'h'
	localparam logic [7:0] CH_0     = 8'h30; // '0'
	localparam logic [7:0] CH_9     = 8'h39; // '9'
	localparam logic [7:0] CH_W     = 8'h77; // 'w'
	localparam logic [7:0] CH_B     = 8'h62; // 'b'
	localparam logic [7:0] CH_UQ    = 8'h51; // 'Q'
	localparam logic [7:0] CH_UK    = 8'h4B; // 'K'
	localparam logic [7:0] CH_LQ    = 8'h71; // 'q'
	localparam logic [7:0] CH_LK    = 8'h6B; // 'k'
	localparam logic [7:0] CH_DASH  = 8'h2D; // '-'
	localparam logic [7:0] CH_SLASH = 8'h2F; // '/'
	localparam logic [7:0] CH_SPACE = 8'h20; // ' '

	localparam int NUM_TYPES = 10;
	localparam logic [6:0] CNT_MAX = 7'd127;

	// one parsed transaction: optional square write, optional summary
	typedef struct packed {
		logic       has_write;
		logic       has_sum;
		logic [5:0] square;
		logic [3:0] piece;
		logic [6:0] piece_count;
		logic [3:0] status;
		logic       white_to_move;
		logic [3:0] castle_flags;
		logic       ep_present;
		logic [2:0] ep_file;
		logic [3:0] ep_rank_digit;
	} rec_t;

	function automatic logic [3:0] piece_code(input logic [7:0] c);
		logic [3:0] r;
		begin
			case (c)
				8'h50: r = 4'd1;  // P
				8'h52: r = 4'd2;  // R
				8'h4E: r = 4'd3;  // N
				8'h42: r = 4'd4;  // B
				8'h51: r = 4'd5;  // Q
				8'h4B: r = 4'd6;  // K
				8'h70: r = 4'd7;  // p
				8'h72: r = 4'd8;  // r
				8'h6E: r = 4'd9;  // n
				8'h62: r = 4'd10; // b
				8'h71: r = 4'd11; // q
				8'h6B: r = 4'd12; // k
				default: r = PC_NONE;
			endcase
			return r;
		end
	endfunction

endpackage

[rtl/fpp_parse.sv]
`timescale 1ns / 1ps
module fpp_parse (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  logic [7:0]    ch,
	input  logic          end_of_string,
	output fpp_pkg::rec_t rec
);

	fpp_pkg::phase_t phase_q, phase_step, phase_d;
	logic [3:0] rank_q, rank_d;
	logic [3:0] file_q, file_d;
	logic [6:0] counts_q [fpp_pkg::NUM_TYPES];
	logic [3:0] castle_q, castle_d;
	logic       turn_q, turn_d;
	logic       ep_pres_q, ep_pres_d;
	logic [2:0] ep_file_q, ep_file_d;
	logic [3:0] ep_dig_q, ep_dig_d;
	logic [3:0] err_q, err_d;

	logic [3:0] pc;
	logic       is_digit, is_file, off_board, place_ok, cnt_inc, is_king;
	logic [3:0] dig;
	logic [3:0] cbit;
	logic [3:0] idx;
	logic [6:0] cnt_new;
	logic [4:0] file_sum;

	// character decode
	always_comb begin
		pc        = fpp_pkg::piece_code(ch);
		is_digit  = (ch >= fpp_pkg::CH_0) && (ch <= fpp_pkg::CH_9);
		is_file   = (ch >= fpp_pkg::CH_A) && (ch <= fpp_pkg::CH_H);
		dig       = 4'(ch - fpp_pkg::CH_0);
		off_board = (rank_q < 4'd1) || (rank_q > 4'd8) || (file_q < 4'd1) || (file_q > 4'd8);
		is_king   = (pc == fpp_pkg::PC_W_KING) || (pc == fpp_pkg::PC_B_KING);
		place_ok  = (phase_q == fpp_pkg::PH_PLACE) && (pc != fpp_pkg::PC_NONE) && !off_board;
		cnt_inc   = place_ok && !is_king;
		idx       = (pc < 4'd6) ? 4'(pc - 4'd1) : 4'(pc - 4'd2);
		cnt_new   = (counts_q[idx] < fpp_pkg::CNT_MAX) ? 7'(counts_q[idx] + 7'd1)
		                                               : counts_q[idx];
		file_sum  = {1'b0, file_q} + {1'b0, dig};
		case (ch)
			fpp_pkg::CH_UK: cbit = 4'b0001;
			fpp_pkg::CH_UQ: cbit = 4'b0010;
			fpp_pkg::CH_LK: cbit = 4'b0100;
			fpp_pkg::CH_LQ: cbit = 4'b1000;
			default:        cbit = 4'b0000;
		endcase
	end

	// next phase
	always_comb begin
		phase_step = phase_q;
		case (phase_q)
			fpp_pkg::PH_PLACE: begin
				if (ch == fpp_pkg::CH_SPACE) begin
					phase_step = fpp_pkg::PH_TURN;
				end else if (ch == fpp_pkg::CH_SLASH || is_digit) begin
					phase_step = fpp_pkg::PH_PLACE;
				end else if (pc == fpp_pkg::PC_NONE || off_board) begin
					phase_step = fpp_pkg::PH_ERROR;
				end
			end
			fpp_pkg::PH_TURN: begin
				phase_step = (ch == fpp_pkg::CH_W || ch == fpp_pkg::CH_B) ?
				             fpp_pkg::PH_SPACE : fpp_pkg::PH_ERROR;
			end
			fpp_pkg::PH_SPACE: begin
				phase_step = (ch == fpp_pkg::CH_SPACE) ? fpp_pkg::PH_CASTLE : fpp_pkg::PH_ERROR;
			end
			fpp_pkg::PH_CASTLE: begin
				if (ch == fpp_pkg::CH_SPACE) begin
					phase_step = fpp_pkg::PH_EP_FILE;
				end else if (ch != fpp_pkg::CH_DASH &&
				             (cbit == 4'd0 || (castle_q & cbit) != 4'd0)) begin
					phase_step = fpp_pkg::PH_ERROR;
				end
			end
			fpp_pkg::PH_EP_FILE: begin
				if (ch == fpp_pkg::CH_DASH) begin
					phase_step = fpp_pkg::PH_DONE;
				end else if (is_file) begin
					phase_step = fpp_pkg::PH_EP_RANK;
				end else begin
					phase_step = fpp_pkg::PH_ERROR;
				end
			end
			fpp_pkg::PH_EP_RANK: begin
				phase_step = is_digit ? fpp_pkg::PH_DONE : fpp_pkg::PH_ERROR;
			end
			default: phase_step = phase_q;
		endcase
		phase_d = end_of_string ? fpp_pkg::PH_PLACE : phase_step;
	end

	// data updates and result record
	always_comb begin
		rank_d    = rank_q;
		file_d    = file_q;
		castle_d  = castle_q;
		turn_d    = turn_q;
		ep_pres_d = ep_pres_q;
		ep_file_d = ep_file_q;
		ep_dig_d  = ep_dig_q;
		err_d     = err_q;
		case (phase_q)
			fpp_pkg::PH_PLACE: begin
				if (ch == fpp_pkg::CH_SPACE) begin
					rank_d = rank_q;
				end else if (ch == fpp_pkg::CH_SLASH) begin
					rank_d = (rank_q > 4'd0) ? 4'(rank_q - 4'd1) : rank_q;
					file_d = 4'd1;
				end else if (pc != fpp_pkg::PC_NONE) begin
					if (off_board) begin
						err_d = fpp_pkg::ST_OFF_BOARD;
					end else begin
						file_d = 4'(file_q + 4'd1);
					end
				end else if (is_digit) begin
					file_d = (file_sum > 5'd15) ? 4'd15 : file_sum[3:0];
				end else begin
					err_d = fpp_pkg::ST_BAD_PLACE;
				end
			end
			fpp_pkg::PH_TURN: begin
				if (ch == fpp_pkg::CH_W) begin
					turn_d = 1'b1;
				end else if (ch == fpp_pkg::CH_B) begin
					turn_d = 1'b0;
				end else begin
					err_d = fpp_pkg::ST_BAD_TURN;
				end
			end
			fpp_pkg::PH_SPACE: begin
				if (ch != fpp_pkg::CH_SPACE) begin
					err_d = fpp_pkg::ST_NO_SPACE;
				end
			end
			fpp_pkg::PH_CASTLE: begin
				if (ch != fpp_pkg::CH_SPACE && ch != fpp_pkg::CH_DASH) begin
					if (cbit == 4'd0) begin
						err_d = fpp_pkg::ST_BAD_CASTLE;
					end else if ((castle_q & cbit) != 4'd0) begin
						err_d = fpp_pkg::ST_DUP_CASTLE;
					end else begin
						castle_d = castle_q | cbit;
					end
				end
			end
			fpp_pkg::PH_EP_FILE: begin
				if (is_file) begin
					ep_pres_d = 1'b0;
					ep_file_d = 3'(ch - fpp_pkg::CH_A);
					ep_dig_d  = 4'd0;
				end else if (ch != fpp_pkg::CH_DASH) begin
					err_d = fpp_pkg::ST_BAD_EP_FILE;
				end
			end
			fpp_pkg::PH_EP_RANK: begin
				if (is_digit) begin
					ep_pres_d = 1'b1;
					ep_dig_d  = dig;
				end else begin
					err_d = fpp_pkg::ST_BAD_EP_RANK;
				end
			end
			default: err_d = err_q;
		endcase

		rec.has_write     = place_ok;
		rec.has_sum       = end_of_string;
		rec.square        = {3'(rank_q - 4'd1), 3'(file_q - 4'd1)};
		rec.piece         = pc;
		rec.piece_count   = cnt_inc ? cnt_new : 7'd0;
		if (err_d != fpp_pkg::ST_OK) begin
			rec.status = err_d;
		end else if (phase_step != fpp_pkg::PH_DONE) begin
			rec.status = fpp_pkg::ST_ENDED_EARLY;
		end else begin
			rec.status = fpp_pkg::ST_OK;
		end
		rec.white_to_move = turn_d;
		rec.castle_flags  = castle_d;
		rec.ep_present    = ep_pres_d;
		rec.ep_file       = ep_file_d;
		rec.ep_rank_digit = ep_dig_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fpp_pkg::PH_PLACE;
			rank_q    <= 4'd8;
			file_q    <= 4'd1;
			castle_q  <= 4'd0;
			turn_q    <= 1'b0;
			ep_pres_q <= 1'b0;
			ep_file_q <= 3'd0;
			ep_dig_q  <= 4'd0;
			err_q     <= fpp_pkg::ST_OK;
			for (int i = 0; i < fpp_pkg::NUM_TYPES; i++) begin
				counts_q[i] <= 7'd0;
			end
		end else if (step) begin
			phase_q <= phase_d;
			if (end_of_string) begin
				rank_q    <= 4'd8;
				file_q    <= 4'd1;
				castle_q  <= 4'd0;
				turn_q    <= 1'b0;
				ep_pres_q <= 1'b0;
				ep_file_q <= 3'd0;
				ep_dig_q  <= 4'd0;
				err_q     <= fpp_pkg::ST_OK;
				for (int i = 0; i < fpp_pkg::NUM_TYPES; i++) begin
					counts_q[i] <= 7'd0;
				end
			end else begin
				rank_q    <= rank_d;
				file_q    <= file_d;
				castle_q  <= castle_d;
				turn_q    <= turn_d;
				ep_pres_q <= ep_pres_d;
				ep_file_q <= ep_file_d;
				ep_dig_q  <= ep_dig_d;
				err_q     <= err_d;
				if (cnt_inc) begin
					counts_q[idx] <= cnt_new;
				end
			end
		end
	end

endmodule

[rtl/fen_position_parser_unit.sv]
`timescale 1ns / 1ps
// A character accepted on the input waits in the input register stage until the parse
// step runs; its results are then written into the record queue for the output port.
// Throughput: one character per cycle while the record queue has room, else stall rises;
// a final character that also places a piece yields two results, sent one after the other.
// Reset (arst_n low, asynchronous) empties the pipeline and returns the parser to
// the start of the placement field; no results are pending afterward.
module fen_position_parser_unit (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       valid,
	output logic       stall,
	input  logic [7:0] ch,
	input  logic       end_of_string,
	// result channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic       kind,
	output logic [5:0] square,
	output logic [3:0] piece,
	output logic [6:0] piece_count,
	output logic [3:0] status,
	output logic       white_to_move,
	output logic [3:0] castle_flags,
	output logic       ep_present,
	output logic [2:0] ep_file,
	output logic [3:0] ep_rank_digit,
	output logic       run_end
);

	// Input register stage: one character waiting for the parse step.
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eos_s1;

	// Record queue: two entries, each holding every result of one character.
	fpp_pkg::rec_t fifo_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       half_q;   // first half (square write) of a two-result record is gone

	fpp_pkg::rec_t rec, head;
	logic in_fire, step, push, pop, full, both;

	assign full    = (count_q == 2'd2);
	// The parse step runs whenever the queue has room; stall only when it does not.
	assign stall   = valid_s1 && full;
	assign in_fire = valid && !stall;
	assign step    = valid_s1 && !full;
	assign push    = step && (rec.has_write || rec.has_sum);

	fpp_parse u_parse (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.ch            (ch_s1),
		.end_of_string (eos_s1),
		.rec           (rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			ch_s1  <= ch;
			eos_s1 <= end_of_string;
		end
	end

	// Output side: a record with a write and a summary is sent in two transactions.
	assign head      = fifo_q[rd_ptr_q];
	assign both      = head.has_write && head.has_sum;
	assign res_valid = (count_q != 2'd0);
	assign pop       = res_valid && !res_stall && (half_q || !both);

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
			half_q   <= 1'b0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
				half_q   <= 1'b0;
			end else if (res_valid && !res_stall) begin
				half_q <= 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= 2'(count_q + 2'd1);
				2'b01:   count_q <= 2'(count_q - 2'd1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_comb begin
		kind          = head.has_sum && (half_q || !head.has_write);
		square        = kind ? 6'd0 : head.square;
		piece         = kind ? fpp_pkg::PC_NONE : head.piece;
		piece_count   = kind ? 7'd0 : head.piece_count;
		status        = kind ? head.status : fpp_pkg::ST_OK;
		white_to_move = head.white_to_move;
		castle_flags  = head.castle_flags;
		ep_present    = head.ep_present;
		ep_file       = head.ep_file;
		ep_rank_digit = head.ep_rank_digit;
		run_end       = kind || !head.has_sum;
	end

endmodule

[rtl/fpp_checker.sv]
`timescale 1ns / 1ps
`include "fen_position_parser_unit_defines.svh"
module fpp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_stall,
	input logic       kind,
	input logic [3:0] piece,
	input logic [6:0] piece_count,
	input logic [3:0] status,
	input logic       run_end
);

	logic is_king;
	logic is_blank;

	assign is_king  = (piece == fpp_pkg::PC_W_KING) || (piece == fpp_pkg::PC_B_KING);
	assign is_blank = (piece == fpp_pkg::PC_NONE);

	`FPP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |=> !res_valid, "result valid during reset")
	`FPP_ASSERT(a_valid_holds, res_valid && res_stall |=> res_valid, "result dropped while stalled")
	`FPP_ASSERT(a_summary_last, res_valid && kind |-> run_end && is_blank, "summary not last")
	`FPP_ASSERT(a_write_status, res_valid && !kind |-> !is_blank && status == fpp_pkg::ST_OK, "bad write")
	`FPP_ASSERT(a_king_count, res_valid && !kind && is_king |-> piece_count == 7'd0, "king with count")

endmodule

bind fen_position_parser_unit fpp_checker u_fpp_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;

	// kinds of result
	localparam logic KIND_WRITE   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// castling flag bits
	localparam logic [3:0] CASTLE_WK = 4'd1;
	localparam logic [3:0] CASTLE_WQ = 4'd2;
	localparam logic [3:0] CASTLE_BK = 4'd4;
	localparam logic [3:0] CASTLE_BQ = 4'd8;

	// piece letters in code order, code = index + 1
	localparam string PIECE_GLYPHS = "PRNBQKprnbqk";

	typedef struct {
		logic       kind;
		logic [5:0] square;
		logic [3:0] piece;
		logic [6:0] piece_count;
		logic [3:0] status;
		logic       white_to_move;
		logic [3:0] castle_flags;
		logic       ep_present;
		logic [2:0] ep_file;
		logic [3:0] ep_rank_digit;
		logic       run_end;
	} fen_result_t;

	// Tracks the parser state, turns each accepted character into the
	// square writes and summaries it should cause, and checks them in order.
	class fen_scoreboard;
		fpp_pkg::phase_t ph;
		logic [3:0]  rank;
		logic [3:0]  file;
		logic [6:0]  counts [fpp_pkg::NUM_TYPES];
		logic [3:0]  castle;
		logic [3:0]  err;
		logic        turn;
		logic        ep_has;
		logic [2:0]  ep_f;
		logic [3:0]  ep_d;
		fen_result_t awaited_results[$];
		int          mismatches;

		function new();
			mismatches = 0;
			clear_position();
		endfunction

		function void clear_position();
			ph = fpp_pkg::PH_PLACE;
			rank = 4'd8;
			file = 4'd1;
			foreach (counts[i]) counts[i] = '0;
			castle = '0;
			err = fpp_pkg::ST_OK;
			turn = 1'b0;
			ep_has = 1'b0;
			ep_f = '0;
			ep_d = '0;
		endfunction

		function fen_result_t snapshot(logic k, logic [5:0] sq, logic [3:0] pc,
				logic [6:0] cnt, logic [3:0] st);
			fen_result_t r;
			r.kind = k;
			r.square = sq;
			r.piece = pc;
			r.piece_count = cnt;
			r.status = st;
			r.white_to_move = turn;
			r.castle_flags = castle;
			r.ep_present = ep_has;
			r.ep_file = ep_f;
			r.ep_rank_digit = ep_d;
			r.run_end = 1'b0;
			return r;
		endfunction

		function void queue_result(fen_result_t r);
			awaited_results = {awaited_results, r};
		endfunction

		function void abort_with(logic [3:0] code);
			err = code;
			ph = fpp_pkg::PH_ERROR;
		endfunction

		function void take_char(logic [7:0] c, logic eos);
			int          queued;
			int          idx;
			logic [3:0]  pc;
			logic [6:0]  cnt;
			logic [4:0]  sum;
			logic [3:0]  flag;
			logic [3:0]  st;
			queued = awaited_results.size();
			pc = fpp_pkg::PC_NONE;
			for (int i = 0; i < 12; i++)
				if (c == 8'(PIECE_GLYPHS[i])) pc = 4'(i + 1);
			case (ph)
				fpp_pkg::PH_PLACE: begin
					if (c == fpp_pkg::CH_SPACE) begin
						ph = fpp_pkg::PH_TURN;
					end else if (c == fpp_pkg::CH_SLASH) begin
						// rank sticks at zero once past the bottom
						if (rank != 0) rank = rank - 1;
						file = 4'd1;
					end else if (pc != fpp_pkg::PC_NONE) begin
						if (rank < 1 || rank > 8 || file < 1 || file > 8) begin
							abort_with(fpp_pkg::ST_OFF_BOARD);
						end else begin
							cnt = '0;
							if (pc != fpp_pkg::PC_W_KING && pc != fpp_pkg::PC_B_KING) begin
								idx = (pc < fpp_pkg::PC_W_KING) ? pc - 1 : pc - 2;
								if (counts[idx] != fpp_pkg::CNT_MAX)
									counts[idx] = counts[idx] + 1;
								cnt = counts[idx];
							end
							queue_result(snapshot(KIND_WRITE,
								6'((rank - 1) * 8 + (file - 1)), pc, cnt, fpp_pkg::ST_OK));
							if (file < 15) file = file + 1;
						end
					end else if (c >= fpp_pkg::CH_0 && c <= fpp_pkg::CH_9) begin
						// empty-square skip, saturating at 15
						sum = 5'(file + (c - fpp_pkg::CH_0));
						file = (sum > 15) ? 4'd15 : sum[3:0];
					end else begin
						abort_with(fpp_pkg::ST_BAD_PLACE);
					end
				end
				fpp_pkg::PH_TURN: begin
					if (c == fpp_pkg::CH_W) begin
						turn = 1'b1;
						ph = fpp_pkg::PH_SPACE;
					end else if (c == fpp_pkg::CH_B) begin
						turn = 1'b0;
						ph = fpp_pkg::PH_SPACE;
					end else begin
						abort_with(fpp_pkg::ST_BAD_TURN);
					end
				end
				fpp_pkg::PH_SPACE: begin
					if (c == fpp_pkg::CH_SPACE) ph = fpp_pkg::PH_CASTLE;
					else abort_with(fpp_pkg::ST_NO_SPACE);
				end
				fpp_pkg::PH_CASTLE: begin
					flag = '0;
					if (c == fpp_pkg::CH_UK) flag = CASTLE_WK;
					else if (c == fpp_pkg::CH_UQ) flag = CASTLE_WQ;
					else if (c == fpp_pkg::CH_LK) flag = CASTLE_BK;
					else if (c == fpp_pkg::CH_LQ) flag = CASTLE_BQ;
					if (c == fpp_pkg::CH_SPACE) begin
						ph = fpp_pkg::PH_EP_FILE;
					end else if (c != fpp_pkg::CH_DASH) begin
						if (flag == 0) abort_with(fpp_pkg::ST_BAD_CASTLE);
						else if ((castle & flag) != 0) abort_with(fpp_pkg::ST_DUP_CASTLE);
						else castle = castle | flag;
					end
				end
				fpp_pkg::PH_EP_FILE: begin
					if (c == fpp_pkg::CH_DASH) begin
						ph = fpp_pkg::PH_DONE;
					end else if (c >= fpp_pkg::CH_A && c <= fpp_pkg::CH_H) begin
						// file noted, square not complete yet
						ep_has = 1'b0;
						ep_f = 3'(c - fpp_pkg::CH_A);
						ep_d = '0;
						ph = fpp_pkg::PH_EP_RANK;
					end else begin
						abort_with(fpp_pkg::ST_BAD_EP_FILE);
					end
				end
				fpp_pkg::PH_EP_RANK: begin
					if (c >= fpp_pkg::CH_0 && c <= fpp_pkg::CH_9) begin
						ep_has = 1'b1;
						ep_d = 4'(c - fpp_pkg::CH_0);
						ph = fpp_pkg::PH_DONE;
					end else begin
						abort_with(fpp_pkg::ST_BAD_EP_RANK);
					end
				end
				default: ;
			endcase
			if (eos) begin
				st = err;
				if (st == fpp_pkg::ST_OK && ph != fpp_pkg::PH_DONE) st = fpp_pkg::ST_ENDED_EARLY;
				queue_result(snapshot(KIND_SUMMARY, '0, fpp_pkg::PC_NONE, '0, st));
				clear_position();
			end
			if (awaited_results.size() > queued)
				awaited_results[awaited_results.size() - 1].run_end = 1'b1;
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
			if (seen !== want) begin
				mismatches++;
				$error("%s: expected %0d, got %0d", name, want, seen);
			end
		endfunction

		function void match_result(fen_result_t got);
			fen_result_t want;
			if (awaited_results.size() == 0) begin
				mismatches++;
				$error("unexpected result: kind %0d square %0d piece %0d status %0d",
					got.kind, got.square, got.piece, got.status);
				return;
			end
			want = awaited_results.pop_front();
			compare_field("kind", 8'(want.kind), 8'(got.kind));
			compare_field("square", 8'(want.square), 8'(got.square));
			compare_field("piece", 8'(want.piece), 8'(got.piece));
			compare_field("piece_count", 8'(want.piece_count), 8'(got.piece_count));
			compare_field("status", 8'(want.status), 8'(got.status));
			compare_field("white_to_move", 8'(want.white_to_move), 8'(got.white_to_move));
			compare_field("castle_flags", 8'(want.castle_flags), 8'(got.castle_flags));
			compare_field("ep_present", 8'(want.ep_present), 8'(got.ep_present));
			compare_field("ep_file", 8'(want.ep_file), 8'(got.ep_file));
			compare_field("ep_rank_digit", 8'(want.ep_rank_digit), 8'(got.ep_rank_digit));
			compare_field("run_end", 8'(want.run_end), 8'(got.run_end));
		endfunction

		function void report_leftover();
			if (awaited_results.size() != 0) begin
				mismatches += awaited_results.size();
				$error("%0d results never arrived", awaited_results.size());
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       valid = 1'b0;
	logic       stall;
	logic [7:0] ch = '0;
	logic       end_of_string = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic       kind;
	logic [5:0] square;
	logic [3:0] piece;
	logic [6:0] piece_count;
	logic [3:0] status;
	logic       white_to_move;
	logic [3:0] castle_flags;
	logic       ep_present;
	logic [2:0] ep_file;
	logic [3:0] ep_rank_digit;
	logic       run_end;

	fen_scoreboard sb = new();
	int            send_gap_pct = 0;
	int            recv_stall_pct = 0;
	int            chars_sent = 0;
	logic [7:0]    fen_text[$];

	fen_position_parser_unit dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	// generous fixed limit; a correct run needs a small fraction of it
	initial begin
		#2_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// random back-pressure on the result side
	always @(posedge clk) begin
		res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// both monitors read the values held just before the edge
	always @(posedge clk) begin
		if (arst_n && valid && !stall) sb.take_char(ch, end_of_string);
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall)
			sb.match_result(fen_result_t'{kind, square, piece, piece_count, status,
				white_to_move, castle_flags, ep_present, ep_file, ep_rank_digit, run_end});
	end

	function automatic void append_char(input logic [7:0] c);
		fen_text = {fen_text, c};
	endfunction

	// One character transaction; random gaps go before valid rises.
	task automatic send_char(input logic [7:0] c, input logic eos);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			valid <= 1'b0;
			@(posedge clk);
		end
		valid <= 1'b1;
		ch <= c;
		end_of_string <= eos;
		@(posedge clk);
		while (stall) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(8'(s[i]), i == s.len() - 1);
	endtask

	// hold off the sender until every awaited result is in
	task automatic drain_results();
		valid <= 1'b0;
		@(posedge clk);
		while (sb.awaited_results.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// Mostly well-formed FEN with random content, some mutated or cut
	// short, some plain noise.
	task automatic compose_fen();
		int         mode;
		int         nranks;
		int         ntok;
		int         k;
		int         rot;
		int         keep;
		logic [3:0] mask;
		logic [7:0] castle_letters [4];
		castle_letters = '{fpp_pkg::CH_UK, fpp_pkg::CH_UQ, fpp_pkg::CH_LK, fpp_pkg::CH_LQ};
		fen_text.delete();
		mode = $urandom_range(0, 99);
		if (mode < 12) begin
			k = $urandom_range(1, 6);
			repeat (k) append_char(8'($urandom_range(0, 255)));
			return;
		end
		// placement; nine ranks drive the row past the bottom
		nranks = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 9) : $urandom_range(1, 3);
		for (int r = 0; r < nranks; r++) begin
			if (r > 0) append_char(fpp_pkg::CH_SLASH);
			ntok = $urandom_range(1, 4);
			for (int t = 0; t < ntok; t++) begin
				if ($urandom_range(0, 2) == 0)
					append_char(($urandom_range(0, 7) == 0) ?
						8'(fpp_pkg::CH_0 + $urandom_range(0, 9)) :
						8'(fpp_pkg::CH_0 + $urandom_range(1, 3)));
				else
					append_char(8'(PIECE_GLYPHS[$urandom_range(0, 11)]));
			end
		end
		append_char(fpp_pkg::CH_SPACE);
		k = $urandom_range(0, 19);
		if (k == 0) append_char(8'($urandom_range(0, 255)));
		else append_char(k[0] ? fpp_pkg::CH_W : fpp_pkg::CH_B);
		append_char(($urandom_range(0, 19) == 0) ?
			8'($urandom_range(0, 255)) : fpp_pkg::CH_SPACE);
		// castling: empty field, dash, or a rotated subset, sometimes doubled
		k = $urandom_range(0, 9);
		if (k == 1) begin
			append_char(fpp_pkg::CH_DASH);
		end else if (k > 1) begin
			mask = 4'($urandom_range(1, 15));
			rot = $urandom_range(0, 3);
			for (int j = 0; j < 4; j++)
				if (mask[(j + rot) % 4]) append_char(castle_letters[(j + rot) % 4]);
			if ($urandom_range(0, 7) == 0)
				append_char($urandom_range(0, 1) ?
					castle_letters[rot] : 8'($urandom_range(0, 255)));
		end
		append_char(fpp_pkg::CH_SPACE);
		k = $urandom_range(0, 11);
		if (k < 5) begin
			append_char(fpp_pkg::CH_DASH);
		end else begin
			append_char((k == 5) ?
				8'($urandom_range(0, 255)) : 8'(fpp_pkg::CH_A + $urandom_range(0, 7)));
			append_char((k == 6) ?
				8'($urandom_range(0, 255)) : 8'(fpp_pkg::CH_0 + $urandom_range(0, 9)));
		end
		// move counters, ignored by the parser
		if ($urandom_range(0, 1) == 1) begin
			append_char(fpp_pkg::CH_SPACE);
			append_char(8'(fpp_pkg::CH_0 + $urandom_range(0, 9)));
			append_char(fpp_pkg::CH_SPACE);
			append_char(8'(fpp_pkg::CH_0 + $urandom_range(1, 9)));
		end
		if ($urandom_range(0, 9) == 0)
			fen_text[$urandom_range(0, fen_text.size() - 1)] = 8'($urandom_range(0, 255));
		if ($urandom_range(0, 7) == 0) begin
			keep = $urandom_range(1, fen_text.size());
			while (fen_text.size() > keep) void'(fen_text.pop_back());
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: king with empty castling field, skip off the board,
		// stray bytes, doubled castling letter, early end, full ep square
		send_text("K w  -");
		send_text("9p");
		send_char(8'hFF, 1'b1);
		send_char(8'h00, 1'b1);
		send_text("k b KK");
		send_text("8");
		send_text("P w Qk h9");
		drain_results();

		// three idling profiles, each ending with a full drain
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					send_gap_pct = 38;
					recv_stall_pct = 87;
				end
				1: begin
					send_gap_pct = 87;
					recv_stall_pct = 38;
				end
				default: begin
					send_gap_pct = 0;
					recv_stall_pct = 0;
				end
			endcase
			while (chars_sent < 25 + (p + 1) * 310) begin
				compose_fen();
				foreach (fen_text[i]) send_char(fen_text[i], i == fen_text.size() - 1);
			end
			drain_results();
		end

		sb.report_leftover();
		if (sb.mismatches == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule
